// ===== hw/rtl/tlse_pkg.sv =====
// Shared types, sizes, opcodes and status codes for the tape-loop stack executor.
// No dependencies; imported by the top level.
package tlse_pkg;

    localparam int TAPE_CELLS  = 32768;
    localparam int STACK_DEPTH = 64;
    localparam int INDEX_BITS  = 16;

    localparam int PTR_W  = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
    localparam int FILL_W = PTR_W + 1;
    localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    localparam int ACT_W  = 3;
    localparam int VAL_W  = 16;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;

    // stream word widths, padded to whole bytes
    localparam int S_BITS   = ACT_W + INDEX_BITS + VAL_W;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS   = INDEX_BITS + 1 + BYTE_W + STAT_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;
    localparam int M_PAD    = M_DATA_W - M_BITS;

    typedef enum logic [ACT_W-1:0] {
        OP_RIGHT = 3'd0,
        OP_LEFT  = 3'd1,
        OP_INC   = 3'd2,
        OP_DEC   = 3'd3,
        OP_OUT   = 3'd4,
        OP_IN    = 3'd5,
        OP_OPEN  = 3'd6,
        OP_CLOSE = 3'd7
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_OVER      = 3'd1,
        STAT_UNDER     = 3'd2,
        STAT_PHIGH     = 3'd3,
        STAT_PLOW      = 3'd4,
        STAT_UNMATCHED = 3'd5,
        STAT_FULL      = 3'd6,
        STAT_HALTED    = 3'd7
    } stat_t;

    // ASCII code of the leading decimal digit; parallel compares per decade
    function automatic logic [BYTE_W-1:0] lead_digit(input logic [VAL_W-1:0] v);
        logic [3:0] d;
        d = 4'd0;
        if (32'(v) >= 32'd10000) begin
            for (int k = 1; k <= 6; k++) begin
                if (32'(v) >= 32'(k * 10000)) d = d + 4'd1;
            end
        end else if (32'(v) >= 32'd1000) begin
            for (int k = 1; k <= 9; k++) begin
                if (32'(v) >= 32'(k * 1000)) d = d + 4'd1;
            end
        end else if (32'(v) >= 32'd100) begin
            for (int k = 1; k <= 9; k++) begin
                if (32'(v) >= 32'(k * 100)) d = d + 4'd1;
            end
        end else if (32'(v) >= 32'd10) begin
            for (int k = 1; k <= 9; k++) begin
                if (32'(v) >= 32'(k * 10)) d = d + 4'd1;
            end
        end else begin
            d = v[3:0];
        end
        return {4'd0, d} + 8'h30;
    endfunction

endpackage

// ===== hw/rtl/tlse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the tape and the loop stack.
module tlse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tape_loop_stack_executor.sv =====
// Top level of the tape-loop stack executor: sequencer, tape and loop stack.
// Depends on tlse_pkg and tlse_ram.
// Usage:
//  - s_ channel: one command word per transfer (opcode, its program index,
//    user value for the input command). m_ channel: one result word per
//    command (next program index, output flag and byte, status).
//  - The accept cycle launches the registered reads of the tape cell
//    under the pointer and the stack top; the execute state then computes,
//    writes back and loads the result register. s_tready is high only in
//    the accept state, so a new command is taken only once the last is done.
//  - m_tvalid rises at the edge that ends the execute state.
//  - A result waiting in the output register does not block the next
//    accept; if m_tready stays low, the block holds in the execute state
//    (no memory writes) until the output register frees up.
//  - Reset (aresetn low, synchronous) clears pointer, stack count, halt
//    flag and the tape fill mark. Tape cells at or above the fill mark read
//    as zero, and the pointer never passes it, so no clearing pass is run
//    and the block is ready in the first cycle after reset.
//  - Any error halts the block; from then on every word returns status
//    halted with next_index equal to cmd_index, until reset.
module tape_loop_stack_executor
    import tlse_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata, low bit up: action[2:0], cmd_index[18:3], in_value[34:19]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata, low bit up: next_index[15:0], out_valid[16], out_byte[24:17],
    // status[27:25]
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;

    // captured command
    op_t                   act_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [VAL_W-1:0]      val_reg;

    // machine state
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;   // cells below this are written
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              halted_reg, halted_next;

    // result register
    logic                  m_valid_reg;
    logic [INDEX_BITS-1:0] nidx_reg, nidx_next;
    logic                  ov_reg, ov_next;
    logic [BYTE_W-1:0]     ob_reg, ob_next;
    stat_t                 stat_reg, stat_next;

    // memory ports
    logic [BYTE_W-1:0]     tape_q;
    logic [INDEX_BITS-1:0] stk_q;
    logic                  tape_we, tape_wr;
    logic [BYTE_W-1:0]     tape_wd;
    logic                  stk_we, stk_wr;

    logic              accept, done, fresh;
    logic [BYTE_W-1:0] cur_cell;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign done     = (state_reg == S_EXEC) && (!m_valid_reg || m_tready);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, stat_reg, ob_reg, ov_reg, nidx_reg};

    // the unwritten cell at the fill mark reads as zero
    assign fresh    = ({1'b0, ptr_reg} == fill_reg);
    assign cur_cell = fresh ? '0 : tape_q;

    assign tape_we = done && tape_wr;
    assign stk_we  = done && stk_wr;

    tlse_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .aclk  (aclk),
        .we    (tape_we),
        .waddr (ptr_reg),
        .wdata (tape_wd),
        .raddr (ptr_reg),
        .rdata (tape_q)
    );

    // push writes at count, top of stack reads at count-1
    tlse_ram #(
        .WIDTH (INDEX_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (cnt_reg[SP_W-1:0]),
        .wdata (idx_reg),
        .raddr (cnt_reg[SP_W-1:0] - SP_W'(1)),
        .rdata (stk_q)
    );

    // command execution; error branches leave pointer, fill mark and stack count untouched and set the halt flag
    always_comb begin
        ptr_next    = ptr_reg;
        fill_next   = fill_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        nidx_next   = idx_reg + INDEX_BITS'(1);
        ov_next     = 1'b0;
        ob_next     = '0;
        stat_next   = STAT_OK;
        tape_wr     = 1'b0;
        tape_wd     = cur_cell;
        stk_wr      = 1'b0;

        if (halted_reg) begin
            stat_next = STAT_HALTED;
        end else begin
            unique case (act_reg)
                OP_RIGHT: begin
                    if (ptr_reg >= PTR_W'(TAPE_CELLS - 1)) begin
                        stat_next = STAT_PHIGH;
                    end else begin
                        ptr_next = ptr_reg + PTR_W'(1);
                        // leaving a fresh cell: zero it so the mark can advance
                        if (fresh) begin
                            tape_wr   = 1'b1;
                            tape_wd   = '0;
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                end
                OP_LEFT: begin
                    if (ptr_reg == '0) begin
                        stat_next = STAT_PLOW;
                    end else begin
                        ptr_next = ptr_reg - PTR_W'(1);
                    end
                end
                OP_INC: begin
                    if (cur_cell == 8'hFF) begin
                        stat_next = STAT_OVER;
                    end else begin
                        tape_wr = 1'b1;
                        tape_wd = cur_cell + 8'd1;
                        if (fresh) fill_next = fill_reg + FILL_W'(1);
                    end
                end
                OP_DEC: begin
                    if (cur_cell == '0) begin
                        stat_next = STAT_UNDER;
                    end else begin
                        tape_wr = 1'b1;
                        tape_wd = cur_cell - 8'd1;
                        if (fresh) fill_next = fill_reg + FILL_W'(1);
                    end
                end
                OP_OUT: begin
                    ov_next = 1'b1;
                    ob_next = cur_cell;
                end
                OP_IN: begin
                    tape_wr = 1'b1;
                    tape_wd = (val_reg > VAL_W'(255)) ? lead_digit(val_reg)
                                                      : val_reg[BYTE_W-1:0];
                    if (fresh) fill_next = fill_reg + FILL_W'(1);
                end
                OP_OPEN: begin
                    if (cnt_reg >= CNT_W'(STACK_DEPTH)) begin
                        stat_next = STAT_FULL;
                    end else begin
                        stk_wr   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                OP_CLOSE: begin
                    if (cnt_reg == '0) begin
                        stat_next = STAT_UNMATCHED;
                    end else if (cur_cell != '0) begin
                        nidx_next = stk_q + INDEX_BITS'(1);
                    end else begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            endcase
            if (stat_next != STAT_OK) begin
                halted_next = 1'b1;
            end
        end

        if (stat_next != STAT_OK) begin
            nidx_next = idx_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: if (done) state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ptr_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (done) begin
                ptr_reg     <= ptr_next;
                fill_reg    <= fill_next;
                cnt_reg     <= cnt_next;
                halted_reg  <= halted_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if (accept) begin
            act_reg <= op_t'(s_tdata[ACT_W-1:0]);
            idx_reg <= s_tdata[ACT_W +: INDEX_BITS];
            val_reg <= s_tdata[ACT_W + INDEX_BITS +: VAL_W];
        end
        if (done) begin
            nidx_reg <= nidx_next;
            ov_reg   <= ov_next;
            ob_reg   <= ob_next;
            stat_reg <= stat_next;
        end
    end

`ifndef ASSERT_OFF
    // pointer never runs ahead of the fill mark
    a_ptr_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, ptr_reg} <= fill_reg)
        else $error("pointer passed tape fill mark");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STACK_DEPTH))
        else $error("loop stack count out of range");

    // a command finished while halted always reports halted
    a_halt_status: assert property (@(posedge aclk) disable iff (!aresetn)
        done && halted_reg |=> stat_reg == STAT_HALTED)
        else $error("halted block returned non-halted status");

    a_out_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ov_reg |-> stat_reg == STAT_OK)
        else $error("output byte flagged on an error result");

    // once halted, only reset clears the flag
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");
`endif

endmodule
